[hdl/atqwb_pkg.sv]
`timescale 1ns / 1ps
// atqwb_pkg: constants, codes and control/status types of the queue weight balancer
// used by every module of the block, depends on nothing
package atqwb_pkg;

    localparam int HISTORY_DEPTH = 256;
    localparam int SUM_BITS      = 24;
    localparam int NQ            = 3;
    localparam int HEAD_W        = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int ADDR_W        = $clog2(NQ * HISTORY_DEPTH);
    localparam int DIFF_W        = SUM_BITS + 1;
    localparam int PROD_W        = SUM_BITS + 16;
    localparam int SPARE_W       = 26;
    localparam int TOTAL_W       = SPARE_W + 2;
    localparam int ADJ_W         = TOTAL_W + 1;
    localparam int ASUM_W        = ADJ_W + 2;
    localparam int DVD_W         = 48;
    localparam int DVS_W         = 32;
    localparam int DCNT_W        = $clog2(DVD_W);
    localparam int MIN_COUNTS    = 5;
    localparam int CFG_IDX_W     = 3;

    typedef logic [SUM_BITS-1:0] sum_t;
    typedef logic [SPARE_W-1:0]  spare_t;
    typedef logic [ADJ_W-1:0]    adj_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DW1 = 3'd0,
        CFG_DW2 = 3'd1,
        CFG_DW3 = 3'd2,
        CFG_WIN = 3'd3,
        CFG_MDD = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OUT_STARTUP,
        OUT_NOSPARE,
        OUT_FALLBACK,
        OUT_WEIGHTS
    } out_kind_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EV_RET,
        ST_EV_PUSH,
        ST_R_ISSUE,
        ST_R_CMP,
        ST_SP_DIFF,
        ST_SP_MUL,
        ST_SP_CHK,
        ST_SP_DIV,
        ST_TOTAL,
        ST_ADJ,
        ST_ASUM,
        ST_A_CHK,
        ST_W_START,
        ST_W_WAIT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic      load;
        logic      rd_head;
        logic      retire;
        logic      push;
        logic      qi_clr;
        logic      qi_inc;
        logic      diff;
        logic      mul;
        logic      spare_zero;
        logic      div_start;
        logic      div_w;
        logic      spare_store;
        logic      total;
        logic      adj;
        logic      asum;
        logic      w_store;
        logic      out_load;
        out_kind_t out_kind;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic bad_q;
        logic full;
        logic nonempty;
        logic stale;
        logic all_seen;
        logic qi_last;
        logic sp_zero;
        logic div_done;
        logic any_spare;
        logic asum_zero;
        logic out_free;
    } sts_t;

endpackage

[hdl/atqwb_div.sv]
`timescale 1ns / 1ps
// atqwb_div: restoring divider, one quotient bit per cycle
// depends on atqwb_pkg
module atqwb_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [atqwb_pkg::DVD_W-1:0]   dividend,
    input  logic [atqwb_pkg::DVS_W-1:0]   divisor,
    output logic [atqwb_pkg::DVD_W-1:0]   quotient,
    output logic                          done
);
    import atqwb_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W:0]    rem_sh;
    logic [DVS_W:0]    rem_sub;
    logic              ge;

    assign rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign ge      = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
                dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) start |-> !busy_reg)
        else $error("divider started while busy");
    assert property (@(posedge aclk) disable iff (!aresetn) done_reg |-> !busy_reg)
        else $error("divider done while still busy");

endmodule

[hdl/atqwb_dp.sv]
`timescale 1ns / 1ps
// atqwb_dp: datapath with config registers, history rings, windowed sums,
// spare and weight arithmetic and the result register; depends on atqwb_pkg, atqwb_div
module atqwb_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  atqwb_pkg::cmd_t                  cmd,
    output atqwb_pkg::sts_t                  sts,
    input  logic                             cfg_valid,
    input  logic [atqwb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                      cfg_data,
    input  logic                             s_mode,
    input  logic [31:0]                      s_timestamp_ms,
    input  logic [1:0]                       s_queue_id,
    input  logic signed [15:0]               s_event_delta,
    input  logic [15:0]                      s_queue_size_1,
    input  logic [15:0]                      s_queue_size_2,
    input  logic [15:0]                      s_queue_size_3,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [15:0]                      m_weight_1,
    output logic [15:0]                      m_weight_2,
    output logic [15:0]                      m_weight_3,
    output logic                             m_in_startup,
    output logic                             m_rebalanced,
    output logic                             m_all_zero_fallback
);
    import atqwb_pkg::*;

    logic [15:0]        dw_reg [NQ];
    logic [15:0]        win_reg;
    logic [15:0]        mdd_reg;

    logic               mode_reg;
    logic [31:0]        time_reg;
    logic [1:0]         qid_reg;
    logic signed [15:0] delta_reg;
    logic [15:0]        size_reg [NQ];

    sum_t               enq_reg [NQ];
    sum_t               deq_reg [NQ];
    logic [HEAD_W-1:0]  head_reg [NQ];
    logic [CNT_W-1:0]   cnt_reg [NQ];
    logic [NQ-1:0]      seen_reg;
    logic [31:0]        last_reg;

    logic [47:0]        ring_mem [NQ*HISTORY_DEPTH];
    logic [47:0]        rd_data_reg;

    logic [1:0]         qi_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    sum_t               e_reg;
    logic [31:0]        prod_a_reg;
    logic [PROD_W-1:0]  prod_b_reg;
    spare_t             spare_reg [NQ];
    logic [TOTAL_W-1:0] total_reg;
    adj_t               adj_reg [NQ];
    logic [ASUM_W-1:0]  asum_reg;
    logic [15:0]        w_reg [NQ];

    logic               m_valid_reg;
    logic [15:0]        m_w_reg [NQ];
    logic               m_st_reg;
    logic               m_rb_reg;
    logic               m_fb_reg;

    logic [1:0]         q_sel;
    logic [1:0]         q_ix;
    logic [HEAD_W-1:0]  head_q;
    logic [CNT_W-1:0]   cnt_q;
    logic [HEAD_W:0]    slot_sum;
    logic [HEAD_W-1:0]  slot;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [31:0]        rd_time;
    logic signed [15:0] rd_delta;
    logic signed [16:0] rd_neg;
    logic [15:0]        rd_mag;
    logic signed [16:0] in_neg;
    logic [15:0]        in_mag;
    logic [SUM_BITS:0]  enq_add;
    logic [SUM_BITS:0]  deq_add;
    logic signed [DIFF_W-1:0] diff_raw;
    logic [DVD_W-1:0]   div_dvd;
    logic [DVS_W-1:0]   div_dvs;
    logic [DVD_W-1:0]   div_q;
    logic               div_done;
    adj_t               adj_next [NQ];

    assign q_sel   = mode_reg ? qi_reg : qid_reg;
    assign q_ix    = (q_sel == 2'd3) ? 2'd0 : q_sel;
    assign head_q  = head_reg[q_ix];
    assign cnt_q   = cnt_reg[q_ix];
    assign slot_sum = (HEAD_W+1)'(head_q) + (HEAD_W+1)'(cnt_q);
    assign slot    = (slot_sum >= (HEAD_W+1)'(HISTORY_DEPTH))
                   ? HEAD_W'(slot_sum - (HEAD_W+1)'(HISTORY_DEPTH)) : slot_sum[HEAD_W-1:0];
    assign rd_addr = ADDR_W'(q_ix) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(head_q);
    assign wr_addr = ADDR_W'(q_ix) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(slot);

    assign rd_time  = rd_data_reg[47:16];
    assign rd_delta = rd_data_reg[15:0];
    assign rd_neg   = -17'(rd_delta);
    assign rd_mag   = (rd_delta > 16'sd0) ? rd_delta : rd_neg[15:0];
    assign in_neg   = -17'(delta_reg);
    assign in_mag   = (delta_reg > 16'sd0) ? delta_reg : in_neg[15:0];
    assign enq_add  = (SUM_BITS+1)'(enq_reg[q_ix]) + (SUM_BITS+1)'(in_mag);
    assign deq_add  = (SUM_BITS+1)'(deq_reg[q_ix]) + (SUM_BITS+1)'(in_mag);
    assign diff_raw = DIFF_W'({1'b0, deq_reg[qi_reg]}) - DIFF_W'({1'b0, enq_reg[qi_reg]});

    assign div_dvd = cmd.div_w ? DVD_W'({adj_reg[qi_reg], 16'b0})
                               : DVD_W'({diff_reg[SUM_BITS-1:0], 16'b0});
    assign div_dvs = cmd.div_w ? DVS_W'(asum_reg) : DVS_W'(e_reg);

    always_comb begin
        for (int q = 0; q < NQ; q++) begin
            logic [ADJ_W-1:0] plus;
            logic [ADJ_W-1:0] three;
            plus  = ADJ_W'(dw_reg[q]) + ADJ_W'({dw_reg[q], 1'b0}) + ADJ_W'(total_reg);
            three = ADJ_W'(spare_reg[q]) + ADJ_W'({spare_reg[q], 1'b0});
            adj_next[q] = (plus > three) ? plus - three : '0;
        end
    end

    atqwb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_q),
        .done     (div_done)
    );

    always_comb begin
        sts.mode      = mode_reg;
        sts.bad_q     = (qid_reg == 2'd3);
        sts.full      = (cnt_q >= CNT_W'(HISTORY_DEPTH));
        sts.nonempty  = (cnt_q != '0);
        sts.stale     = (last_reg >= {16'b0, win_reg}) && (rd_time < last_reg - {16'b0, win_reg});
        sts.all_seen  = &seen_reg;
        sts.qi_last   = (qi_reg == 2'd2);
        sts.sp_zero   = diff_reg[DIFF_W-1] || (diff_reg == '0) ||
                        (PROD_W'(prod_a_reg) > prod_b_reg);
        sts.div_done  = div_done;
        sts.any_spare = (spare_reg[0] != '0) || (spare_reg[1] != '0) || (spare_reg[2] != '0);
        sts.asum_zero = (asum_reg == '0);
        sts.out_free  = !m_valid_reg || m_ready;
    end

    // ring storage
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            ring_mem[wr_addr] <= {time_reg, delta_reg};
        end
        if (cmd.rd_head) begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    // payload, arithmetic and result registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg    <= s_mode;
            time_reg    <= s_timestamp_ms;
            qid_reg     <= s_queue_id;
            delta_reg   <= s_event_delta;
            size_reg[0] <= s_queue_size_1;
            size_reg[1] <= s_queue_size_2;
            size_reg[2] <= s_queue_size_3;
        end
        if (cmd.diff) begin
            diff_reg <= (diff_raw == '0) ? DIFF_W'(MIN_COUNTS) : diff_raw;
            e_reg    <= (enq_reg[qi_reg] < SUM_BITS'(MIN_COUNTS))
                      ? SUM_BITS'(MIN_COUNTS) : enq_reg[qi_reg];
        end
        if (cmd.mul) begin
            prod_a_reg <= size_reg[qi_reg] * win_reg;
            prod_b_reg <= PROD_W'(mdd_reg) * PROD_W'(diff_reg[SUM_BITS-1:0]);
        end
        if (cmd.spare_zero) begin
            spare_reg[qi_reg] <= '0;
        end
        if (cmd.spare_store) begin
            spare_reg[qi_reg] <= (div_q > DVD_W'({SPARE_W{1'b1}}))
                               ? {SPARE_W{1'b1}} : div_q[SPARE_W-1:0];
        end
        if (cmd.total) begin
            total_reg <= TOTAL_W'(spare_reg[0]) + TOTAL_W'(spare_reg[1]) +
                         TOTAL_W'(spare_reg[2]);
        end
        if (cmd.adj) begin
            for (int q = 0; q < NQ; q++) begin
                adj_reg[q] <= adj_next[q];
            end
        end
        if (cmd.asum) begin
            asum_reg <= ASUM_W'(adj_reg[0]) + ASUM_W'(adj_reg[1]) + ASUM_W'(adj_reg[2]);
        end
        if (cmd.w_store) begin
            w_reg[qi_reg] <= (div_q > DVD_W'(16'hFFFF)) ? 16'hFFFF : div_q[15:0];
        end
        if (cmd.out_load) begin
            case (cmd.out_kind)
                OUT_STARTUP: begin
                    for (int q = 0; q < NQ; q++) m_w_reg[q] <= dw_reg[q];
                    m_st_reg <= 1'b1;
                    m_rb_reg <= 1'b0;
                    m_fb_reg <= 1'b0;
                end
                OUT_FALLBACK: begin
                    for (int q = 0; q < NQ; q++) m_w_reg[q] <= dw_reg[q];
                    m_st_reg <= 1'b0;
                    m_rb_reg <= 1'b1;
                    m_fb_reg <= 1'b1;
                end
                OUT_WEIGHTS: begin
                    for (int q = 0; q < NQ; q++) m_w_reg[q] <= w_reg[q];
                    m_st_reg <= 1'b0;
                    m_rb_reg <= 1'b1;
                    m_fb_reg <= 1'b0;
                end
                default: begin
                    for (int q = 0; q < NQ; q++) m_w_reg[q] <= dw_reg[q];
                    m_st_reg <= 1'b0;
                    m_rb_reg <= 1'b0;
                    m_fb_reg <= 1'b0;
                end
            endcase
        end
    end

    // control state, sums, ring pointers, output valid and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int q = 0; q < NQ; q++) begin
                dw_reg[q]   <= 16'd21845;
                enq_reg[q]  <= '0;
                deq_reg[q]  <= '0;
                head_reg[q] <= '0;
                cnt_reg[q]  <= '0;
            end
            win_reg     <= 16'd5000;
            mdd_reg     <= 16'd2000;
            seen_reg    <= '0;
            last_reg    <= '0;
            qi_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_DW1: dw_reg[0] <= cfg_data;
                    CFG_DW2: dw_reg[1] <= cfg_data;
                    CFG_DW3: dw_reg[2] <= cfg_data;
                    CFG_WIN: win_reg   <= cfg_data;
                    CFG_MDD: mdd_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.qi_clr) begin
                qi_reg <= '0;
            end else if (cmd.qi_inc) begin
                qi_reg <= qi_reg + 2'd1;
            end
            if (cmd.retire) begin
                if (rd_delta > 16'sd0) begin
                    enq_reg[q_ix] <= (enq_reg[q_ix] > SUM_BITS'(rd_mag))
                                   ? enq_reg[q_ix] - SUM_BITS'(rd_mag) : '0;
                end else begin
                    deq_reg[q_ix] <= (deq_reg[q_ix] > SUM_BITS'(rd_mag))
                                   ? deq_reg[q_ix] - SUM_BITS'(rd_mag) : '0;
                end
                head_reg[q_ix] <= (head_q == HEAD_W'(HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;
                cnt_reg[q_ix]  <= cnt_q - 1'b1;
            end
            if (cmd.push) begin
                if (delta_reg > 16'sd0) begin
                    enq_reg[q_ix] <= enq_add[SUM_BITS] ? {SUM_BITS{1'b1}} : enq_add[SUM_BITS-1:0];
                end else begin
                    deq_reg[q_ix] <= deq_add[SUM_BITS] ? {SUM_BITS{1'b1}} : deq_add[SUM_BITS-1:0];
                end
                cnt_reg[q_ix]  <= cnt_q + 1'b1;
                seen_reg[q_ix] <= 1'b1;
                last_reg       <= time_reg;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_weight_1          = m_w_reg[0];
    assign m_weight_2          = m_w_reg[1];
    assign m_weight_3          = m_w_reg[2];
    assign m_in_startup        = m_st_reg;
    assign m_rebalanced        = m_rb_reg;
    assign m_all_zero_fallback = m_fb_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg[0] <= CNT_W'(HISTORY_DEPTH)) && (cnt_reg[1] <= CNT_W'(HISTORY_DEPTH)) &&
        (cnt_reg[2] <= CNT_W'(HISTORY_DEPTH)))
        else $error("ring count beyond depth");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before taken");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.retire |-> (cnt_q != '0) && $past(cmd.rd_head))
        else $error("retire without a fresh head word");

endmodule

[hdl/atqwb_ctrl.sv]
`timescale 1ns / 1ps
// atqwb_ctrl: sequencer for event logging, retirement, spare and weight steps
// depends on atqwb_pkg
module atqwb_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  atqwb_pkg::sts_t sts,
    output atqwb_pkg::cmd_t cmd
);
    import atqwb_pkg::*;

    state_t    state_reg, state_next;
    out_kind_t kind_reg, kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= OUT_NOSPARE;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        cmd          = '0;
        cmd.out_kind = kind_reg;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.mode) begin
                    if (!sts.all_seen) begin
                        kind_next  = OUT_STARTUP;
                        state_next = ST_FIN;
                    end else begin
                        cmd.qi_clr = 1'b1;
                        state_next = ST_R_ISSUE;
                    end
                end else if (sts.bad_q) begin
                    state_next = ST_IDLE;
                end else if (sts.full) begin
                    cmd.rd_head = 1'b1;
                    state_next  = ST_EV_RET;
                end else begin
                    state_next = ST_EV_PUSH;
                end
            end
            ST_EV_RET: begin
                cmd.retire = 1'b1;
                state_next = ST_EV_PUSH;
            end
            ST_EV_PUSH: begin
                cmd.push   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_R_ISSUE: begin
                if (sts.nonempty) begin
                    cmd.rd_head = 1'b1;
                    state_next  = ST_R_CMP;
                end else if (sts.qi_last) begin
                    cmd.qi_clr = 1'b1;
                    state_next = ST_SP_DIFF;
                end else begin
                    cmd.qi_inc = 1'b1;
                end
            end
            ST_R_CMP: begin
                if (sts.stale) begin
                    cmd.retire = 1'b1;
                    state_next = ST_R_ISSUE;
                end else if (sts.qi_last) begin
                    cmd.qi_clr = 1'b1;
                    state_next = ST_SP_DIFF;
                end else begin
                    cmd.qi_inc = 1'b1;
                    state_next = ST_R_ISSUE;
                end
            end
            ST_SP_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = ST_SP_MUL;
            end
            ST_SP_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_SP_CHK;
            end
            ST_SP_CHK: begin
                if (sts.sp_zero) begin
                    cmd.spare_zero = 1'b1;
                    if (sts.qi_last) begin
                        state_next = ST_TOTAL;
                    end else begin
                        cmd.qi_inc = 1'b1;
                        state_next = ST_SP_DIFF;
                    end
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_SP_DIV;
                end
            end
            ST_SP_DIV: begin
                if (sts.div_done) begin
                    cmd.spare_store = 1'b1;
                    if (sts.qi_last) begin
                        state_next = ST_TOTAL;
                    end else begin
                        cmd.qi_inc = 1'b1;
                        state_next = ST_SP_DIFF;
                    end
                end
            end
            ST_TOTAL: begin
                if (!sts.any_spare) begin
                    kind_next  = OUT_NOSPARE;
                    state_next = ST_FIN;
                end else begin
                    cmd.total  = 1'b1;
                    state_next = ST_ADJ;
                end
            end
            ST_ADJ: begin
                cmd.adj    = 1'b1;
                state_next = ST_ASUM;
            end
            ST_ASUM: begin
                cmd.asum   = 1'b1;
                state_next = ST_A_CHK;
            end
            ST_A_CHK: begin
                if (sts.asum_zero) begin
                    kind_next  = OUT_FALLBACK;
                    state_next = ST_FIN;
                end else begin
                    cmd.qi_clr = 1'b1;
                    state_next = ST_W_START;
                end
            end
            ST_W_START: begin
                cmd.div_start = 1'b1;
                cmd.div_w     = 1'b1;
                state_next    = ST_W_WAIT;
            end
            ST_W_WAIT: begin
                if (sts.div_done) begin
                    cmd.w_store = 1'b1;
                    if (sts.qi_last) begin
                        kind_next  = OUT_WEIGHTS;
                        state_next = ST_FIN;
                    end else begin
                        cmd.qi_inc = 1'b1;
                        state_next = ST_W_START;
                    end
                end
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/adaptive_three_queue_weight_balancer.sv]
`timescale 1ns / 1ps
// adaptive_three_queue_weight_balancer: top level, controller plus datapath
// depends on atqwb_pkg, atqwb_ctrl, atqwb_dp
//
//  channel  direction  handshake           word
//  s_       in         s_valid / s_ready   event (mode 0) or query (mode 1)
//  m_       out        m_valid / m_ready   weights and flags, one per query
//  cfg_     in         cfg_valid/cfg_ready register index and 16-bit data
//
// event: decode and push; a full ring first retires its oldest entry
// query: startup returns the default weights; otherwise stale entries are retired
//   one at a time, then up to 6 divisions run on the shared serial divider
// reset: synchronous, no clearing pass; ring contents undefined until written
// a finished result waits in the output register while the next word is taken
module adaptive_three_queue_weight_balancer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_mode,
    input  logic [31:0]                      s_timestamp_ms,
    input  logic [1:0]                       s_queue_id,
    input  logic signed [15:0]               s_event_delta,
    input  logic [15:0]                      s_queue_size_1,
    input  logic [15:0]                      s_queue_size_2,
    input  logic [15:0]                      s_queue_size_3,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [15:0]                      m_weight_1,
    output logic [15:0]                      m_weight_2,
    output logic [15:0]                      m_weight_3,
    output logic                             m_in_startup,
    output logic                             m_rebalanced,
    output logic                             m_all_zero_fallback,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [atqwb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                      cfg_data
);
    import atqwb_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    atqwb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    atqwb_dp u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .sts                 (sts),
        .cfg_valid           (cfg_valid),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_mode              (s_mode),
        .s_timestamp_ms      (s_timestamp_ms),
        .s_queue_id          (s_queue_id),
        .s_event_delta       (s_event_delta),
        .s_queue_size_1      (s_queue_size_1),
        .s_queue_size_2      (s_queue_size_2),
        .s_queue_size_3      (s_queue_size_3),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_weight_1          (m_weight_1),
        .m_weight_2          (m_weight_2),
        .m_weight_3          (m_weight_3),
        .m_in_startup        (m_in_startup),
        .m_rebalanced        (m_rebalanced),
        .m_all_zero_fallback (m_all_zero_fallback)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking bench for the adaptive three-queue weight balancer
// depends on atqwb_pkg and the block itself; predicts weights and flags per query
module testbench;
    import atqwb_pkg::*;

    typedef struct {
        logic        mode;
        logic [31:0] ts;
        logic [1:0]  qid;
        logic [15:0] delta;
        logic [15:0] size [3];
    } word_t;

    typedef struct {
        logic [15:0] w [3];
        logic        startup;
        logic        rebal;
        logic        fallback;
    } weights_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic s_mode = 0;
    logic [31:0] s_timestamp_ms = 0;
    logic [1:0] s_queue_id = 0;
    logic signed [15:0] s_event_delta = 0;
    logic [15:0] s_queue_size_1 = 0, s_queue_size_2 = 0, s_queue_size_3 = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [15:0] m_weight_1, m_weight_2, m_weight_3;
    logic m_in_startup, m_rebalanced, m_all_zero_fallback;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = 0;
    logic [15:0] cfg_data = 0;

    adaptive_three_queue_weight_balancer DUT (.*);

    always #4 aclk = ~aclk;

    // predictor state
    logic [15:0] dflt_w [3];
    logic [15:0] win_ms, drain_ms;
    longint unsigned enq_sum [3], deq_sum [3];
    logic [31:0] hist_ts [3][HISTORY_DEPTH];
    longint hist_delta [3][HISTORY_DEPTH];
    int hist_head [3], hist_cnt [3];
    bit seen [3];
    logic [31:0] last_ts;

    word_t pending [$];
    weights_t expected_weights [$];
    int errors = 0;
    int tx_idle_pct = 17, rx_idle_pct = 60;
    logic [31:0] now_ts = 0;
    bit in_fire = 0;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic longint unsigned sub_sat(longint unsigned a, longint unsigned b);
        return a > b ? a - b : 0;
    endfunction

    function automatic void drop_oldest(int q);
        longint d;
        d = hist_delta[q][hist_head[q]];
        if (d > 0) enq_sum[q] = sub_sat(enq_sum[q], d);
        else deq_sum[q] = sub_sat(deq_sum[q], -d);
        hist_head[q] = (hist_head[q] + 1) % HISTORY_DEPTH;
        hist_cnt[q]--;
    endfunction

    function automatic longint unsigned spare_of(int q, longint unsigned sz);
        longint diff;
        longint unsigned e, s;
        diff = longint'(deq_sum[q]) - longint'(enq_sum[q]);
        e = enq_sum[q];
        if (diff == 0) diff = MIN_COUNTS;
        if (diff <= 0) return 0;
        if (sz * win_ms > longint'(drain_ms) * diff) return 0;
        if (e < MIN_COUNTS) e = MIN_COUNTS;
        s = (longint'(diff) << 16) / e;
        return s > ((64'd1 << 26) - 1) ? ((64'd1 << 26) - 1) : s;
    endfunction

    task automatic predict_balance(input word_t it);
        weights_t r;
        longint unsigned sp [3], adj [3], tot, asum, w, sumcap;
        longint d, low;
        int slot;
        bit any;
        tot = 0; asum = 0; any = 0;
        sumcap = (64'd1 << SUM_BITS) - 1;
        if (it.mode == 1'b0) begin
            if (it.qid == 2'd3) return;
            d = longint'($signed(it.delta));
            if (hist_cnt[it.qid] >= HISTORY_DEPTH) drop_oldest(it.qid);
            slot = (hist_head[it.qid] + hist_cnt[it.qid]) % HISTORY_DEPTH;
            hist_ts[it.qid][slot] = it.ts;
            hist_delta[it.qid][slot] = d;
            hist_cnt[it.qid]++;
            if (d > 0) enq_sum[it.qid] = enq_sum[it.qid] + d > sumcap ? sumcap : enq_sum[it.qid] + d;
            else deq_sum[it.qid] = deq_sum[it.qid] - d > sumcap ? sumcap : deq_sum[it.qid] - d;
            seen[it.qid] = 1;
            last_ts = it.ts;
            return;
        end
        for (int q = 0; q < 3; q++) r.w[q] = dflt_w[q];
        r.startup = 0; r.rebal = 0; r.fallback = 0;
        if (!(seen[0] && seen[1] && seen[2])) begin
            r.startup = 1;
            expected_weights = {expected_weights, r};
            return;
        end
        low = longint'(last_ts) - longint'(win_ms);
        for (int q = 0; q < 3; q++)
            while (hist_cnt[q] > 0 && longint'(hist_ts[q][hist_head[q]]) < low)
                drop_oldest(q);
        for (int q = 0; q < 3; q++) begin
            sp[q] = spare_of(q, it.size[q]);
            tot += sp[q];
            if (sp[q] > 0) any = 1;
        end
        if (any) begin
            r.rebal = 1;
            for (int q = 0; q < 3; q++) begin
                adj[q] = sub_sat(3 * longint'(dflt_w[q]) + tot, 3 * sp[q]);
                asum += adj[q];
            end
            if (asum == 0) r.fallback = 1;
            else for (int q = 0; q < 3; q++) begin
                w = (adj[q] << 16) / asum;
                r.w[q] = w > 16'hFFFF ? 16'hFFFF : w[15:0];
            end
        end
        expected_weights = {expected_weights, r};
    endtask

    // input handshake taken at the rising edge
    always @(posedge aclk) begin
        in_fire = aresetn && s_valid && s_ready;
    end

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_fire) begin
                predict_balance(pending.pop_front());
            end
            if ((!s_valid || in_fire) && pending.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_valid <= 1;
                s_mode <= pending[0].mode;
                s_timestamp_ms <= pending[0].ts;
                s_queue_id <= pending[0].qid;
                s_event_delta <= pending[0].delta;
                s_queue_size_1 <= pending[0].size[0];
                s_queue_size_2 <= pending[0].size[1];
                s_queue_size_3 <= pending[0].size[2];
            end else if (in_fire) begin
                s_valid <= 0;
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        weights_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_weights.size() == 0) report("result with no query pending");
            else begin
                e = expected_weights.pop_front();
                if (m_weight_1 !== e.w[0]) report($sformatf("weight_1 %0d exp %0d", m_weight_1, e.w[0]));
                if (m_weight_2 !== e.w[1]) report($sformatf("weight_2 %0d exp %0d", m_weight_2, e.w[1]));
                if (m_weight_3 !== e.w[2]) report($sformatf("weight_3 %0d exp %0d", m_weight_3, e.w[2]));
                if (m_in_startup !== e.startup) report("in_startup");
                if (m_rebalanced !== e.rebal) report("rebalanced");
                if (m_all_zero_fallback !== e.fallback) report("all_zero_fallback");
            end
        end
    end

    task automatic add_event(input logic [1:0] q, input logic [15:0] d, input logic [31:0] t);
        word_t it;
        it.mode = 0; it.ts = t; it.qid = q; it.delta = d;
        for (int i = 0; i < 3; i++) it.size[i] = 16'($urandom);
        pending = {pending, it};
    endtask

    task automatic add_query(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c);
        word_t it;
        it.mode = 1; it.ts = $urandom; it.qid = 2'($urandom); it.delta = 16'($urandom);
        it.size[0] = a; it.size[1] = b; it.size[2] = c;
        pending = {pending, it};
    endtask

    task automatic drain_all();
        while (pending.size() > 0 || s_valid || expected_weights.size() > 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] v);
        @(negedge aclk);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_DW1: dflt_w[0] = v;
            CFG_DW2: dflt_w[1] = v;
            CFG_DW3: dflt_w[2] = v;
            CFG_WIN: win_ms = v;
            CFG_MDD: drain_ms = v;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic random_phase(input int n);
        int kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(99);
            now_ts += $urandom_range(3000);
            if (kind < 5) add_event(2'd3, 16'($urandom), now_ts);
            else if (kind < 65)
                add_event(2'($urandom_range(2)),
                    ($urandom_range(3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(400)) - 250),
                    ($urandom_range(40) == 0) ? $urandom : now_ts);
            else if (kind < 95)
                add_query($urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(50)),
                          $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(50)),
                          $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(50)));
            else add_query(0, 0, 0);
        end
    endtask

    initial begin
        dflt_w = '{21845, 21845, 21845};
        win_ms = 5000; drain_ms = 2000; last_ts = 0;
        for (int q = 0; q < 3; q++) begin
            enq_sum[q] = 0; deq_sum[q] = 0; hist_head[q] = 0; hist_cnt[q] = 0; seen[q] = 0;
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn <= 1;

        // startup, bad queue, extremes, stale entries, no spare, clamping
        add_query(16'hFFFF, 0, 0);
        add_event(2'd3, 16'h8000, 32'd10);
        add_event(2'd0, 16'h7FFF, 32'd0);
        add_event(2'd1, 16'h8000, 32'd100);
        add_query(0, 0, 0);
        add_event(2'd2, 16'h0000, 32'd200);
        add_query(0, 0, 0);
        add_query(16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_event(2'd0, 16'hFFF0, 32'd300);
        add_event(2'd2, 16'hFF00, 32'd400);
        add_query(1, 2, 3);
        add_event(2'd1, 16'h0001, 32'hFFFF_FFFF);
        add_query(0, 0, 0);
        add_event(2'd0, 16'h8000, 32'hFFFF_FFF0);
        add_event(2'd1, 16'h8000, 32'hFFFF_FFF1);
        add_event(2'd2, 16'h0005, 32'hFFFF_FFF2);
        add_query(0, 0, 16'hFFFF);
        // fill a ring beyond depth
        for (int i = 0; i < HISTORY_DEPTH + 4; i++) add_event(2'd1, 16'hFFFE, 32'hFFFF_FFF3);
        add_query(10, 10, 10);
        drain_all();
        now_ts = 0;

        write_reg(CFG_DW1, 0); write_reg(CFG_DW2, 0); write_reg(CFG_DW3, 0);
        write_reg(CFG_WIN, 1); write_reg(CFG_MDD, 16'hFFFF);
        random_phase(100);
        drain_all();

        write_reg(CFG_DW1, 16'hFFFF); write_reg(CFG_DW2, 16'h1234); write_reg(CFG_DW3, 16'h0001);
        write_reg(CFG_WIN, 16'hFFFF); write_reg(CFG_MDD, 1);
        random_phase(100);
        drain_all();

        write_reg(CFG_DW1, 21845); write_reg(CFG_DW2, 21845); write_reg(CFG_DW3, 21845);
        write_reg(CFG_WIN, 5000); write_reg(CFG_MDD, 2000);
        random_phase(150);
        drain_all();

        tx_idle_pct = 60; rx_idle_pct = 17;
        write_reg(CFG_DW1, 16'($urandom)); write_reg(CFG_MDD, 16'($urandom_range(1, 65535)));
        random_phase(200);
        drain_all();

        tx_idle_pct = 0; rx_idle_pct = 0;
        write_reg(CFG_WIN, 16'($urandom_range(1, 65535)));
        random_phase(170);
        drain_all();

        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
